[hw/rtl/spo2rl_pkg.sv]
// shared types, constants and the saturation lookup table for the spo2 estimator
`timescale 1ns / 1ps

package spo2rl_pkg;

    localparam int SUM_WIDTH_DEF      = 56;
    localparam int COUNT_WIDTH_DEF    = 16;
    localparam int LOG_FRAC_BITS_DEF  = 16;
    localparam int TABLE_ENTRIES      = 43;
    localparam int MANT_FRAC          = 30;
    localparam int IDX_WIDTH          = 6;
    localparam int SPO2_WIDTH         = 7;
    localparam int RATIO_HIGH_KNEE    = 66;
    localparam int RATIO_LOW_KNEE     = 50;
    localparam int RATIO_SCALE        = 100;
    localparam int IN_TDATA_WIDTH     = 72;
    localparam int OUT_TDATA_WIDTH    = 16;

    typedef enum logic [3:0] {
        T_IDLE,
        T_SQ_IR,
        T_SQ_RED,
        T_BEAT,
        T_LOG_N,
        T_LOG_IR,
        T_LOG_RED,
        T_DIV_START,
        T_DIV,
        T_MAP,
        T_EMIT
    } top_state_t;

    typedef enum logic [1:0] {
        LG_IDLE,
        LG_NORM,
        LG_MANT,
        LG_SQR
    } log_state_t;

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_DONE
    } div_state_t;

    function automatic logic [SPO2_WIDTH-1:0] spo2_lookup(input logic [IDX_WIDTH-1:0] idx);
        logic [SPO2_WIDTH-1:0] v;
        case (idx) inside
            [6'd0:6'd3]:   v = 7'd100;
            [6'd4:6'd9]:   v = 7'd99;
            [6'd10:6'd14]: v = 7'd98;
            [6'd15:6'd20]: v = 7'd97;
            [6'd21:6'd26]: v = 7'd96;
            [6'd27:6'd32]: v = 7'd95;
            [6'd33:6'd37]: v = 7'd94;
            default:       v = 7'd93;
        endcase
        return v;
    endfunction

endpackage

[hw/rtl/spo2_ratio_lut_estimator.sv]
// top level: square-sum accumulation, beat counting and estimate sequencer
//
// channel   | ports                           | content
// ----------+---------------------------------+---------------------------------------------
// in        | s_axis_tvalid/tready/tdata/tuser| sample request: ir/red pairs, beat; tuser=kind
// out       | m_axis_tvalid/tready/tdata      | both spo2 values and estimate_done
// config    | cfg_we, cfg_wdata               | beats_per_estimate
//
// a sample without estimate passes square ir, square red, beat, emit to output valid
// an estimate adds three log2 runs, one serial divide and the map state; a zero sum
// goes straight to the map state and a zero denominator log skips the divide
// reset clears all sums, counts and spo2 values; beats_per_estimate resets to 3
// no new request is taken while busy or while the output waits on m_axis_tready
`timescale 1ns / 1ps

module spo2_ratio_lut_estimator #(
    parameter int SUM_WIDTH         = spo2rl_pkg::SUM_WIDTH_DEF,
    parameter int COUNT_WIDTH       = spo2rl_pkg::COUNT_WIDTH_DEF,
    parameter int LOG_FRACTION_BITS = spo2rl_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_axis_tvalid,
    output logic                                   s_axis_tready,
    // ir_first, red_first, ir_second, red_second, beat, zero fill
    input  logic [spo2rl_pkg::IN_TDATA_WIDTH-1:0]  s_axis_tdata,
    // action
    input  logic                                   s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  logic                                   m_axis_tready,
    // spo2_plain, spo2_differential, estimate_done, zero fill
    output logic [spo2rl_pkg::OUT_TDATA_WIDTH-1:0] m_axis_tdata,
    input  logic                                   cfg_we,
    input  logic [7:0]                             cfg_wdata
);

    localparam int KW  = $clog2(SUM_WIDTH);
    localparam int LRW = KW + LOG_FRACTION_BITS;
    localparam int LW  = LRW + 1;
    localparam int NW  = LW + 7;
    localparam int RW  = NW + 1;
    localparam int SW  = spo2rl_pkg::SPO2_WIDTH;
    localparam logic signed [RW-1:0] HIGH_KNEE = RW'(spo2rl_pkg::RATIO_HIGH_KNEE);
    localparam logic signed [RW-1:0] LOW_KNEE  = RW'(spo2rl_pkg::RATIO_LOW_KNEE);
    localparam logic signed [RW-1:0] SAT_KNEE  =
        RW'(spo2rl_pkg::RATIO_HIGH_KNEE + spo2rl_pkg::TABLE_ENTRIES - 1);

    spo2rl_pkg::top_state_t state_reg, state_next;

    logic [7:0]             bpe_reg;
    logic [SUM_WIDTH-1:0]   ir_sum_reg  [2];
    logic [SUM_WIDTH-1:0]   red_sum_reg [2];
    logic [COUNT_WIDTH-1:0] cnt_reg     [2];
    logic [7:0]             beats_reg   [2];
    logic [SW-1:0]          spo2_reg    [2];

    logic                   kind_reg;
    logic                   beat_reg;
    logic [16:0]            ir_mag_reg;
    logic [16:0]            red_mag_reg;
    logic                   zero_reg;
    logic                   done_reg;
    logic [LRW-1:0]         ln_reg;
    logic signed [LW-1:0]   li_reg;
    logic signed [LW-1:0]   lr_reg;
    logic signed [RW-1:0]   ratio_reg;
    logic                   out_valid_reg;
    logic [spo2rl_pkg::OUT_TDATA_WIDTH-1:0] out_data_reg;

    // input unpacking and magnitudes
    logic [15:0]          ir_f, red_f, ir_s, red_s;
    logic [16:0]          ir_d, red_d;
    logic signed [17:0]   ir_v, red_v;
    logic [17:0]          ir_neg, red_neg;

    assign ir_f  = s_axis_tdata[15:0];
    assign red_f = s_axis_tdata[31:16];
    assign ir_s  = s_axis_tdata[47:32];
    assign red_s = s_axis_tdata[63:48];
    assign ir_d  = {ir_s[15], ir_s} - {ir_f[15], ir_f};
    assign red_d = {red_s[15], red_s} - {red_f[15], red_f};
    assign ir_v  = s_axis_tuser ? {ir_d, 1'b0} : {{2{ir_f[15]}}, ir_f};
    assign red_v = s_axis_tuser ? {red_d, 1'b0} : {{2{red_f[15]}}, red_f};
    assign ir_neg  = -ir_v;
    assign red_neg = -red_v;

    logic accept;
    assign accept = s_axis_tvalid && s_axis_tready;
    assign s_axis_tready = (state_reg == spo2rl_pkg::T_IDLE) && !out_valid_reg;

    // shared squarer and saturating add
    logic [16:0]          sq_op;
    logic [33:0]          sq;
    logic [SUM_WIDTH-1:0] sum_sel;
    logic [SUM_WIDTH:0]   sum_add;
    logic [SUM_WIDTH-1:0] sum_sat;

    assign sq_op   = (state_reg == spo2rl_pkg::T_SQ_IR) ? ir_mag_reg : red_mag_reg;
    assign sq      = sq_op * sq_op;
    assign sum_sel = (state_reg == spo2rl_pkg::T_SQ_IR) ? ir_sum_reg[kind_reg]
                                                         : red_sum_reg[kind_reg];
    assign sum_add = {1'b0, sum_sel} + (SUM_WIDTH+1)'(sq);
    assign sum_sat = sum_add[SUM_WIDTH] ? '1 : sum_add[SUM_WIDTH-1:0];

    logic est_hit;
    logic sums_zero;
    assign est_hit   = beat_reg && (beats_reg[kind_reg] == bpe_reg);
    assign sums_zero = (ir_sum_reg[kind_reg] == '0) || (red_sum_reg[kind_reg] == '0);

    // log2 unit
    logic                 log_start;
    logic [SUM_WIDTH-1:0] log_x;
    logic                 log_done;
    logic [LRW-1:0]       log_res;
    logic signed [LW-1:0] log_minus_n;

    assign log_minus_n = $signed({1'b0, log_res}) - $signed({1'b0, ln_reg});

    always_comb
    begin
        case (state_reg)
            spo2rl_pkg::T_LOG_N:  log_x = ir_sum_reg[kind_reg];
            spo2rl_pkg::T_LOG_IR: log_x = red_sum_reg[kind_reg];
            default:              log_x = SUM_WIDTH'(cnt_reg[kind_reg]);
        endcase
    end

    spo2rl_log2 #(
        .SUM_WIDTH     (SUM_WIDTH),
        .LOG_FRAC_BITS (LOG_FRACTION_BITS)
    ) u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (log_start),
        .x      (log_x),
        .done   (log_done),
        .result (log_res)
    );

    // divider
    logic                  div_start;
    logic signed [LW+7:0]  num_full;
    logic                  div_done;
    logic signed [RW-1:0]  div_quot;

    assign num_full = lr_reg * $signed(8'(spo2rl_pkg::RATIO_SCALE));

    spo2rl_div #(
        .NUM_WIDTH (NW),
        .DEN_WIDTH (LW)
    ) u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (num_full[NW-1:0]),
        .den   (li_reg),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ratio to table index
    logic [spo2rl_pkg::IDX_WIDTH-1:0] idx;
    logic signed [RW-1:0]             ratio_hi, ratio_lo;

    assign ratio_hi = ratio_reg - HIGH_KNEE;
    assign ratio_lo = ratio_reg - LOW_KNEE;

    always_comb
    begin
        if (zero_reg)
            idx = '0;
        else if (ratio_reg > SAT_KNEE)
            idx = spo2rl_pkg::IDX_WIDTH'(spo2rl_pkg::TABLE_ENTRIES - 1);
        else if (ratio_reg > HIGH_KNEE)
            idx = ratio_hi[spo2rl_pkg::IDX_WIDTH-1:0];
        else if (ratio_reg > LOW_KNEE)
            idx = ratio_lo[spo2rl_pkg::IDX_WIDTH-1:0];
        else
            idx = '0;
    end

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spo2rl_pkg::T_IDLE:
            begin
                if (accept)
                    state_next = spo2rl_pkg::T_SQ_IR;
            end
            spo2rl_pkg::T_SQ_IR:
                state_next = spo2rl_pkg::T_SQ_RED;
            spo2rl_pkg::T_SQ_RED:
                state_next = spo2rl_pkg::T_BEAT;
            spo2rl_pkg::T_BEAT:
            begin
                if (!est_hit)
                    state_next = spo2rl_pkg::T_EMIT;
                else if (sums_zero)
                    state_next = spo2rl_pkg::T_MAP;
                else
                    state_next = spo2rl_pkg::T_LOG_N;
            end
            spo2rl_pkg::T_LOG_N:
            begin
                if (log_done)
                    state_next = spo2rl_pkg::T_LOG_IR;
            end
            spo2rl_pkg::T_LOG_IR:
            begin
                if (log_done)
                    state_next = spo2rl_pkg::T_LOG_RED;
            end
            spo2rl_pkg::T_LOG_RED:
            begin
                if (log_done)
                    state_next = spo2rl_pkg::T_DIV_START;
            end
            spo2rl_pkg::T_DIV_START:
            begin
                if (li_reg == '0)
                    state_next = spo2rl_pkg::T_MAP;
                else
                    state_next = spo2rl_pkg::T_DIV;
            end
            spo2rl_pkg::T_DIV:
            begin
                if (div_done)
                    state_next = spo2rl_pkg::T_MAP;
            end
            spo2rl_pkg::T_MAP:
                state_next = spo2rl_pkg::T_EMIT;
            spo2rl_pkg::T_EMIT:
                state_next = spo2rl_pkg::T_IDLE;
            default:
                state_next = spo2rl_pkg::T_IDLE;
        endcase
    end

    always_comb
    begin
        log_start = 1'b0;
        div_start = 1'b0;
        case (state_reg)
            spo2rl_pkg::T_BEAT:      log_start = est_hit && !sums_zero;
            spo2rl_pkg::T_LOG_N:     log_start = log_done;
            spo2rl_pkg::T_LOG_IR:    log_start = log_done;
            spo2rl_pkg::T_DIV_START: div_start = (li_reg != '0);
            default:
            begin
                log_start = 1'b0;
                div_start = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= spo2rl_pkg::T_IDLE;
            bpe_reg       <= 8'd3;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 2; i++)
            begin
                ir_sum_reg[i]  <= '0;
                red_sum_reg[i] <= '0;
                cnt_reg[i]     <= '0;
                beats_reg[i]   <= '0;
                spo2_reg[i]    <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
                bpe_reg <= cfg_wdata;
            if (state_reg == spo2rl_pkg::T_EMIT)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
            case (state_reg)
                spo2rl_pkg::T_SQ_IR:
                    ir_sum_reg[kind_reg] <= sum_sat;
                spo2rl_pkg::T_SQ_RED:
                begin
                    red_sum_reg[kind_reg] <= sum_sat;
                    if (cnt_reg[kind_reg] != '1)
                        cnt_reg[kind_reg] <= cnt_reg[kind_reg] + 1'b1;
                    if (beat_reg)
                        beats_reg[kind_reg] <= beats_reg[kind_reg] + 1'b1;
                end
                spo2rl_pkg::T_MAP:
                begin
                    // both kinds restart; only the estimating kind keeps a value
                    for (int i = 0; i < 2; i++)
                    begin
                        ir_sum_reg[i]  <= '0;
                        red_sum_reg[i] <= '0;
                        cnt_reg[i]     <= '0;
                        beats_reg[i]   <= '0;
                        spo2_reg[i]    <= (1'(i) == kind_reg) ?
                                          spo2rl_pkg::spo2_lookup(idx) : '0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            kind_reg    <= s_axis_tuser;
            beat_reg    <= s_axis_tdata[64];
            ir_mag_reg  <= ir_v[17] ? ir_neg[16:0] : ir_v[16:0];
            red_mag_reg <= red_v[17] ? red_neg[16:0] : red_v[16:0];
            done_reg    <= 1'b0;
            zero_reg    <= 1'b0;
        end
        case (state_reg)
            spo2rl_pkg::T_BEAT:
                zero_reg <= sums_zero;
            spo2rl_pkg::T_LOG_N:
            begin
                if (log_done)
                    ln_reg <= log_res;
            end
            spo2rl_pkg::T_LOG_IR:
            begin
                if (log_done)
                    li_reg <= log_minus_n;
            end
            spo2rl_pkg::T_LOG_RED:
            begin
                if (log_done)
                    lr_reg <= log_minus_n;
            end
            spo2rl_pkg::T_DIV_START:
            begin
                if (li_reg == '0)
                    zero_reg <= 1'b1;
            end
            spo2rl_pkg::T_DIV:
            begin
                if (div_done)
                    ratio_reg <= div_quot;
            end
            spo2rl_pkg::T_MAP:
                done_reg <= 1'b1;
            spo2rl_pkg::T_EMIT:
                out_data_reg <= {1'b0, done_reg, spo2_reg[1], spo2_reg[0]};
            default:
            begin
            end
        endcase
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

[hw/rtl/spo2rl_log2.sv]
// iterative fixed-point log2: normalize by halving steps, then one squaring per fraction bit
`timescale 1ns / 1ps

module spo2rl_log2 #(
    parameter int SUM_WIDTH     = spo2rl_pkg::SUM_WIDTH_DEF,
    parameter int LOG_FRAC_BITS = spo2rl_pkg::LOG_FRAC_BITS_DEF
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          start,
    input  logic [SUM_WIDTH-1:0]                          x,
    output logic                                          done,
    output logic [$clog2(SUM_WIDTH)+LOG_FRAC_BITS-1:0]    result
);

    localparam int KW = $clog2(SUM_WIDTH);
    localparam int MF = spo2rl_pkg::MANT_FRAC;
    localparam int CW = $clog2(LOG_FRAC_BITS + 1);

    spo2rl_pkg::log_state_t state_reg, state_next;
    logic [SUM_WIDTH-1:0]     x_reg;
    logic [KW-1:0]            k_reg;
    logic [$clog2(KW)-1:0]    sidx_reg;
    logic [MF:0]              m_reg;
    logic [LOG_FRAC_BITS-1:0] frac_reg;
    logic [CW-1:0]            cnt_reg;
    logic                     done_reg;

    logic [KW-1:0]          shamt;
    logic [SUM_WIDTH-1:0]   top_bits;
    logic [2*MF+1:0]        prod;
    logic [MF+1:0]          sq;

    assign shamt    = KW'(1) << sidx_reg;
    assign top_bits = x_reg >> (SUM_WIDTH - int'(shamt));
    assign prod     = m_reg * m_reg;
    assign sq       = prod[2*MF+1:MF];

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spo2rl_pkg::LG_IDLE:
            begin
                if (start)
                    state_next = spo2rl_pkg::LG_NORM;
            end
            spo2rl_pkg::LG_NORM:
            begin
                if (sidx_reg == '0)
                    state_next = spo2rl_pkg::LG_MANT;
            end
            spo2rl_pkg::LG_MANT:
                state_next = spo2rl_pkg::LG_SQR;
            spo2rl_pkg::LG_SQR:
            begin
                if (cnt_reg == CW'(LOG_FRAC_BITS - 1))
                    state_next = spo2rl_pkg::LG_IDLE;
            end
            default:
                state_next = spo2rl_pkg::LG_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spo2rl_pkg::LG_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == spo2rl_pkg::LG_SQR) &&
                         (cnt_reg == CW'(LOG_FRAC_BITS - 1));
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            spo2rl_pkg::LG_IDLE:
            begin
                x_reg    <= x;
                k_reg    <= KW'(SUM_WIDTH - 1);
                sidx_reg <= $clog2(KW)'(KW - 1);
            end
            spo2rl_pkg::LG_NORM:
            begin
                // shift left if the top bits of this step are clear
                if (top_bits == '0)
                begin
                    x_reg <= x_reg << shamt;
                    k_reg <= k_reg - shamt;
                end
                sidx_reg <= sidx_reg - 1'b1;
            end
            spo2rl_pkg::LG_MANT:
            begin
                m_reg    <= x_reg[SUM_WIDTH-1 -: MF+1];
                frac_reg <= '0;
                cnt_reg  <= '0;
            end
            spo2rl_pkg::LG_SQR:
            begin
                if (sq[MF+1])
                    m_reg <= sq[MF+1:1];
                else
                    m_reg <= sq[MF:0];
                frac_reg <= {frac_reg[LOG_FRAC_BITS-2:0], sq[MF+1]};
                cnt_reg  <= cnt_reg + 1'b1;
            end
            default:
            begin
                x_reg <= x_reg;
            end
        endcase
    end

    assign done   = done_reg;
    assign result = {k_reg, frac_reg};

endmodule

[hw/rtl/spo2rl_div.sv]
// bit-serial restoring divider with quotient floored toward minus infinity
`timescale 1ns / 1ps

module spo2rl_div #(
    parameter int NUM_WIDTH = 32,
    parameter int DEN_WIDTH = 24
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        start,
    input  logic signed [NUM_WIDTH-1:0] num,
    input  logic signed [DEN_WIDTH-1:0] den,
    output logic                        done,
    output logic signed [NUM_WIDTH:0]   quot
);

    localparam int CW = $clog2(NUM_WIDTH + 1);

    spo2rl_pkg::div_state_t state_reg, state_next;
    logic [NUM_WIDTH-1:0] q_reg;
    logic [DEN_WIDTH-1:0] rem_reg;
    logic [DEN_WIDTH-1:0] den_reg;
    logic                 neg_reg;
    logic [CW-1:0]        cnt_reg;

    logic [DEN_WIDTH:0]   rem_sh;
    logic [DEN_WIDTH:0]   rem_sub;
    logic [NUM_WIDTH:0]   q_ext;

    assign rem_sh  = {rem_reg, q_reg[NUM_WIDTH-1]};
    assign rem_sub = rem_sh - {1'b0, den_reg};
    assign q_ext   = {1'b0, q_reg};

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            spo2rl_pkg::DV_IDLE:
            begin
                if (start)
                    state_next = spo2rl_pkg::DV_RUN;
            end
            spo2rl_pkg::DV_RUN:
            begin
                if (cnt_reg == CW'(NUM_WIDTH - 1))
                    state_next = spo2rl_pkg::DV_DONE;
            end
            default:
                state_next = spo2rl_pkg::DV_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= spo2rl_pkg::DV_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == spo2rl_pkg::DV_IDLE)
        begin
            q_reg   <= num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : num;
            den_reg <= den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : den;
            neg_reg <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
            rem_reg <= '0;
            cnt_reg <= '0;
        end
        else if (state_reg == spo2rl_pkg::DV_RUN)
        begin
            if (!rem_sub[DEN_WIDTH])
            begin
                rem_reg <= rem_sub[DEN_WIDTH-1:0];
                q_reg   <= {q_reg[NUM_WIDTH-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_sh[DEN_WIDTH-1:0];
                q_reg   <= {q_reg[NUM_WIDTH-2:0], 1'b0};
            end
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign done = (state_reg == spo2rl_pkg::DV_DONE);
    // negative quotients with a remainder step one further down
    assign quot = neg_reg ? $signed(-q_ext - (NUM_WIDTH+1)'(rem_reg != '0))
                          : $signed(q_ext);

endmodule
